// ----- rtl/fba_pkg.sv -----
// fba_pkg: shared widths, codes and types of the fit block allocator
// used by every module under rtl; depends on nothing

package fba_pkg;

  localparam int MAX_BLOCKS_DEF = 64;

  localparam int SIZE_W        = 16;
  localparam int LOAD_INDEX_W  = 6;
  localparam int BLOCK_INDEX_W = 6;
  localparam int NUM_BLOCKS_W  = 7;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;

  // command codes carried in s_tuser
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FIT_MODE   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_BLOCKS = 1'b1;

  // fit mode codes
  localparam logic MODE_FIRST_FIT = 1'b0;
  localparam logic MODE_BEST_FIT  = 1'b1;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SIZE_W-1:0] want;
    logic [SIZE_W-1:0] best_size;
  } tok_t;

  // one result item
  typedef struct packed {
    logic [BLOCK_INDEX_W-1:0] block_index;
    logic                     allocated;
  } res_t;

endpackage

// ----- rtl/fba_cell.sv -----
// fba_cell: one table entry (block size and occupied flag) and one stage
// of the search chain; depends on fba_pkg

module fba_cell #(
  parameter int IDXW    = 6,
  parameter int CELL_ID = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fit_mode,
  input  logic [fba_pkg::NUM_BLOCKS_W-1:0]  num_blocks,
  input  logic                              load_en,
  input  logic [fba_pkg::LOAD_INDEX_W-1:0]  load_index,
  input  logic [fba_pkg::SIZE_W-1:0]        load_size,
  input  logic                              claim_en,
  input  logic [IDXW-1:0]                   claim_idx,
  input  fba_pkg::tok_t                     tok_in,
  input  logic [IDXW-1:0]                   idx_in,
  output fba_pkg::tok_t                     tok_out,
  output logic [IDXW-1:0]                   idx_out
);

  localparam int LW = (IDXW > fba_pkg::NUM_BLOCKS_W) ? IDXW : fba_pkg::NUM_BLOCKS_W;
  localparam int CW = (IDXW > fba_pkg::LOAD_INDEX_W) ? IDXW : fba_pkg::LOAD_INDEX_W;
  localparam logic [LW-1:0]   LIM_ID  = LW'(CELL_ID);
  localparam logic [CW-1:0]   LOAD_ID = CW'(CELL_ID);
  localparam logic [IDXW-1:0] MY_IDX  = IDXW'(CELL_ID);

  logic [fba_pkg::SIZE_W-1:0] size;
  logic                       taken;
  logic                       load_hit;
  logic                       claim_hit;
  logic                       active;
  logic                       fits;
  logic                       pick;
  fba_pkg::tok_t              tok_next;
  logic [IDXW-1:0]            idx_next;

  assign load_hit  = load_en && (CW'(load_index) == LOAD_ID);
  assign claim_hit = claim_en && (claim_idx == MY_IDX);
  assign active    = LIM_ID < LW'(num_blocks);
  assign fits      = tok_in.valid && active && !taken && (size >= tok_in.want);
  assign pick      = fits && (!tok_in.found ||
                     (fit_mode == fba_pkg::MODE_BEST_FIT && size < tok_in.best_size));

  always_comb begin
    tok_next           = tok_in;
    tok_next.found     = tok_in.found || fits;
    tok_next.best_size = pick ? size : tok_in.best_size;
    idx_next           = pick ? MY_IDX : idx_in;
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      size <= load_size;
    end
    idx_out <= idx_next;
    if (rst) begin
      taken   <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (load_hit) begin
        taken <= 1'b0;
      end else if (claim_hit) begin
        taken <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/fba_out_buf.sv -----
// fba_out_buf: two-place result buffer in front of the master side
// depends on fba_pkg

module fba_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fba_pkg::res_t push_res,
  output logic          full,
  output logic          m_tvalid,
  input  logic          m_tready,
  output fba_pkg::res_t m_res
);

  logic          skid_valid;
  fba_pkg::res_t skid_res;
  logic          pop;

  assign pop  = m_tvalid && m_tready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (m_tvalid && !pop) begin
        skid_valid <= 1'b1;
        skid_res   <= push_res;
      end else begin
        m_tvalid <= 1'b1;
        m_res    <= push_res;
      end
    end else if (pop) begin
      if (skid_valid) begin
        m_res      <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/fit_block_allocator.sv -----
// fit_block_allocator: first-fit / best-fit partition allocator, top level
// depends on fba_pkg, fba_cell and fba_out_buf
//
// The block table lives in a row of MAX_BLOCKS cells, one entry per cell. A load
// request writes one entry and gives no result, so loads can follow back to back
// while s_tready is high. An allocation request sends a search token down the
// row, one cell per cycle, so m_tvalid rises once the token has passed the last
// cell; the chosen cell is marked occupied at the same edge that pushes the result.
// The block takes no new request until the search has ended, so the length of the
// row sets how long an allocation request holds the input side. s_tready stays low
// while a search is under way and while two results wait on the master side.

module fit_block_allocator #(
  parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // load_index [5:0], item_size [21:6], zero [23:22]
  input  logic [fba_pkg::S_TDATA_W-1:0]   s_tdata,
  // cmd [0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // allocated [0], block_index [6:1], zero [7]
  output logic [fba_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [fba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fba_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic                               fit_mode;
  logic [fba_pkg::NUM_BLOCKS_W-1:0]   num_blocks;
  logic                               busy;
  logic                               accept;
  logic                               load_en;
  logic [fba_pkg::LOAD_INDEX_W-1:0]   load_index;
  logic [fba_pkg::SIZE_W-1:0]         item_size;
  logic                               done;
  logic                               claim_en;
  logic [IDXW-1:0]                    claim_idx;
  logic                               buf_full;
  fba_pkg::res_t                      res;
  fba_pkg::res_t                      m_res;

  fba_pkg::tok_t   tok [MAX_BLOCKS+1];
  logic [IDXW-1:0] idx [MAX_BLOCKS+1];

  assign load_index = s_tdata[fba_pkg::LOAD_INDEX_W-1:0];
  assign item_size  = s_tdata[fba_pkg::LOAD_INDEX_W +: fba_pkg::SIZE_W];

  assign s_tready = !busy && !buf_full;
  assign accept   = s_tvalid && s_tready;
  assign load_en  = accept && (s_tuser == fba_pkg::CMD_LOAD);

  always_comb begin
    tok[0].valid     = accept && (s_tuser == fba_pkg::CMD_REQUEST);
    tok[0].found     = 1'b0;
    tok[0].want      = item_size;
    tok[0].best_size = '0;
    idx[0]           = '0;
  end

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    fba_cell #(
      .IDXW    (IDXW),
      .CELL_ID (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .fit_mode   (fit_mode),
      .num_blocks (num_blocks),
      .load_en    (load_en),
      .load_index (load_index),
      .load_size  (item_size),
      .claim_en   (claim_en),
      .claim_idx  (claim_idx),
      .tok_in     (tok[g]),
      .idx_in     (idx[g]),
      .tok_out    (tok[g+1]),
      .idx_out    (idx[g+1])
    );
  end

  assign done      = tok[MAX_BLOCKS].valid;
  assign claim_en  = done && tok[MAX_BLOCKS].found;
  assign claim_idx = idx[MAX_BLOCKS];

  assign res.allocated   = tok[MAX_BLOCKS].found;
  assign res.block_index = tok[MAX_BLOCKS].found ?
                           fba_pkg::BLOCK_INDEX_W'(idx[MAX_BLOCKS]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode   <= fba_pkg::MODE_FIRST_FIT;
      num_blocks <= '0;
      busy       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fba_pkg::CFG_FIT_MODE:   fit_mode   <= cfg_data[0];
          fba_pkg::CFG_NUM_BLOCKS: num_blocks <= cfg_data;
          default: ;
        endcase
      end
      if (tok[0].valid) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  fba_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (done),
    .push_res (res),
    .full     (buf_full),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = fba_pkg::M_TDATA_W'(m_res);

endmodule

// ----- rtl/fba_checker.sv -----
// fba_checker: port-level assertions for fit_block_allocator, with its bind
// depends on fba_pkg and the top level's ports

module fba_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fba_pkg::M_TDATA_W-1:0]   m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no block, no index
  a_zero_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[fba_pkg::M_TDATA_W-1:1] == '0)
    else $error("index set on a failed allocation");

  // a search request blocks the input side next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == fba_pkg::CMD_REQUEST |=> !s_tready)
    else $error("input taken during a search");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result after reset");

endmodule

bind fit_block_allocator fba_checker u_fba_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/tb_fit_block_allocator.sv -----
// tb_fit_block_allocator: self-checking bench for the first-fit / best-fit block allocator
// drives load and allocation requests, predicts every grant and checks the result stream
// depends on fba_pkg and fit_block_allocator

module tb_fit_block_allocator;
  import fba_pkg::*;

  localparam int NBLK       = MAX_BLOCKS_DEF;
  localparam int SETTLE     = NBLK + 8;
  localparam int RAND_ITEMS = 750;
  localparam int LIMIT      = 600000;
  localparam int NPLAN      = 26;

  typedef enum logic [1:0] {ROW_LOAD, ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   sel;
    logic [LOAD_INDEX_W-1:0]  idx;
    logic [SIZE_W-1:0]        size;
    logic                     typed;
    logic                     exp_alloc;
    logic [BLOCK_INDEX_W-1:0] exp_idx;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state
  logic [SIZE_W-1:0]       part_size [NBLK];
  logic                    part_busy [NBLK];
  logic                    mode_cfg = MODE_FIRST_FIT;
  logic [NUM_BLOCKS_W-1:0] nblk_cfg = '0;

  res_t grants_due [$];
  row_t plan [NPLAN];

  int errors = 0;
  int cycles = 0;
  int n_loads = 0;
  int n_requests = 0;
  int n_granted = 0;
  int n_phases = 0;
  int rand_items = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  fit_block_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d grants still due", cycles, grants_due.size());
      $display("tb_fit_block_allocator: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    errors++;
  endtask

  function automatic res_t grant_partition(input logic [SIZE_W-1:0] want);
    int   lim;
    int   pick;
    int   i;
    res_t r;
    lim  = (nblk_cfg > NBLK) ? NBLK : int'(nblk_cfg);
    pick = -1;
    r    = '0;
    for (i = 0; i < lim; i++) begin
      if (!part_busy[i] && part_size[i] >= want) begin
        if (pick < 0)
          pick = i;
        else if (mode_cfg == MODE_BEST_FIT && part_size[i] < part_size[pick])
          pick = i;
      end
    end
    if (pick >= 0) begin
      part_busy[pick] = 1'b1;
      r.allocated     = 1'b1;
      r.block_index   = pick[BLOCK_INDEX_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3, 4: return SIZE_W'($urandom_range(0, 15));
      5, 6: return SIZE_W'($urandom_range(0, 1023));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    if (tx_calm)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 95)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request on the slave side; called just after a rising edge
  task automatic push_item(input logic cmd, input logic [LOAD_INDEX_W-1:0] idx,
                           input logic [SIZE_W-1:0] size, input logic typed,
                           input res_t typed_res);
    int   gap;
    res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, size, idx};
    do @(posedge clk); while (s_tready !== 1'b1);
    if (cmd == CMD_LOAD) begin
      part_size[idx] = size;
      part_busy[idx] = 1'b0;
      n_loads++;
    end else begin
      r = grant_partition(size);
      n_requests++;
      if (r.allocated)
        n_granted++;
      grants_due.push_back(typed ? typed_res : r);
    end
  endtask

  // sender holds off until every grant is back, then lets the pipeline drain
  task automatic settle_results();
    s_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    settle_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIT_MODE)
      mode_cfg = val[0];
    else
      nblk_cfg = val;
  endtask

  always @(posedge clk) begin : result_side
    int   roll;
    int   rx_hold;
    res_t got;
    res_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got = res_t'(m_tdata[BLOCK_INDEX_W:0]);
      if (grants_due.size() == 0) begin
        report_mismatch("result with nothing pending, allocated", got.allocated, 0);
      end else begin
        want = grants_due.pop_front();
        if (got.allocated !== want.allocated)
          report_mismatch("allocated", got.allocated, want.allocated);
        if (got.block_index !== want.block_index)
          report_mismatch("block_index", got.block_index, want.block_index);
      end
    end
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= 1'b1;
      if (!rx_calm) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          rx_hold = $urandom_range(15, 60);
        else if (roll < 25)
          rx_hold = $urandom_range(1, 3);
      end
    end
  end

  initial begin
    int                      r;
    int                      k;
    int                      count;
    int                      lim;
    logic                    mode;
    logic [NUM_BLOCKS_W-1:0] nb;
    logic [LOAD_INDEX_W-1:0] idx;
    res_t                    typed_res;

    plan = '{
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'h0000, 1'b1, 1'b0, 6'd0},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'hFFFF, 1'b1, 1'b0, 6'd0},
      '{ROW_LOAD, CFG_FIT_MODE,   6'd0, 16'hFFFF, 1'b0, 1'b0, 6'd0},
      '{ROW_LOAD, CFG_FIT_MODE,   6'd1, 16'd10,   1'b0, 1'b0, 6'd0},
      '{ROW_LOAD, CFG_FIT_MODE,   6'd2, 16'd10,   1'b0, 1'b0, 6'd0},
      '{ROW_LOAD, CFG_FIT_MODE,   6'd3, 16'd0,    1'b0, 1'b0, 6'd0},
      '{ROW_CFG,  CFG_NUM_BLOCKS, 6'd0, 16'd4,    1'b0, 1'b0, 6'd0},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd9, 16'd5,    1'b1, 1'b1, 6'd0},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'd10,   1'b1, 1'b1, 6'd1},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'd0,    1'b1, 1'b1, 6'd2},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'd0,    1'b1, 1'b1, 6'd3},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'd0,    1'b1, 1'b0, 6'd0},
      // reload of a taken entry frees it
      '{ROW_LOAD, CFG_FIT_MODE,   6'd1, 16'd10,   1'b0, 1'b0, 6'd0},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'd10,   1'b1, 1'b1, 6'd1},
      '{ROW_CFG,  CFG_FIT_MODE,   6'd0, {15'd0, MODE_BEST_FIT}, 1'b0, 1'b0, 6'd0},
      '{ROW_LOAD, CFG_FIT_MODE,   6'd0, 16'hFFFF, 1'b0, 1'b0, 6'd0},
      '{ROW_LOAD, CFG_FIT_MODE,   6'd2, 16'd7,    1'b0, 1'b0, 6'd0},
      '{ROW_LOAD, CFG_FIT_MODE,   6'd3, 16'd7,    1'b0, 1'b0, 6'd0},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'd1,    1'b0, 1'b0, 6'd0},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'd7,    1'b0, 1'b0, 6'd0},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'd8,    1'b0, 1'b0, 6'd0},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'hFFFF, 1'b1, 1'b0, 6'd0},
      '{ROW_CFG,  CFG_NUM_BLOCKS, 6'd0, 16'd1,    1'b0, 1'b0, 6'd0},
      '{ROW_LOAD, CFG_FIT_MODE,   6'd0, 16'd5,    1'b0, 1'b0, 6'd0},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'd6,    1'b1, 1'b0, 6'd0},
      '{ROW_REQ,  CFG_FIT_MODE,   6'd0, 16'd5,    1'b1, 1'b1, 6'd0}
    };

    for (k = 0; k < NBLK; k++) begin
      part_size[k] = '0;
      part_busy[k] = 1'b0;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (r = 0; r < NPLAN; r++) begin
      typed_res.allocated   = plan[r].exp_alloc;
      typed_res.block_index = plan[r].exp_idx;
      case (plan[r].kind)
        ROW_CFG:  set_register(plan[r].sel, plan[r].size[CFG_DATA_W-1:0]);
        ROW_LOAD: push_item(CMD_LOAD, plan[r].idx, plan[r].size, 1'b0, typed_res);
        default:  push_item(CMD_REQUEST, plan[r].idx, plan[r].size, plan[r].typed, typed_res);
      endcase
    end

    // fill the whole table so any block count is legal from here on
    for (k = 0; k < NBLK; k++) begin
      push_item(CMD_LOAD, LOAD_INDEX_W'(k), rand_size(), 1'b0, '0);
      rand_items++;
    end

    while (rand_items < RAND_ITEMS) begin
      case (n_phases)
        0: begin mode = MODE_FIRST_FIT; nb = NUM_BLOCKS_W'(NBLK); end
        1: begin mode = MODE_BEST_FIT;  nb = NUM_BLOCKS_W'(NBLK); end
        2: begin mode = MODE_BEST_FIT;  nb = '1; end
        3: begin mode = MODE_FIRST_FIT; nb = '0; end
        4: begin mode = MODE_FIRST_FIT; nb = NUM_BLOCKS_W'(1); end
        5: begin mode = MODE_BEST_FIT;  nb = NUM_BLOCKS_W'(2); end
        default: begin
          mode = $urandom_range(0, 1) ? MODE_BEST_FIT : MODE_FIRST_FIT;
          case ($urandom_range(0, 9))
            0: nb = NUM_BLOCKS_W'($urandom_range(NBLK + 1, 127));
            1: nb = NUM_BLOCKS_W'(NBLK);
            default: nb = NUM_BLOCKS_W'($urandom_range(1, NBLK));
          endcase
        end
      endcase
      set_register(CFG_FIT_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
      set_register(CFG_NUM_BLOCKS, nb);
      tx_calm = (n_phases % 4 == 3);
      rx_calm = (n_phases % 5 == 2);
      lim = (nb > NBLK) ? NBLK : int'(nb);
      count = $urandom_range(40, 75);
      for (k = 0; k < count; k++) begin
        if ($urandom_range(0, 59) == 0)
          settle_results();
        if (lim > 0 && $urandom_range(0, 3) != 0)
          idx = LOAD_INDEX_W'($urandom_range(0, lim - 1));
        else
          idx = LOAD_INDEX_W'($urandom_range(0, NBLK - 1));
        if ($urandom_range(0, 99) < 40)
          push_item(CMD_LOAD, idx, rand_size(), 1'b0, '0);
        else
          push_item(CMD_REQUEST, idx, rand_size(), 1'b0, '0);
        rand_items++;
      end
      n_phases++;
    end

    settle_results();
    if (grants_due.size() != 0)
      report_mismatch("grants left over", grants_due.size(), 0);

    $display("covered %0d loads and %0d allocation requests (%0d granted) over %0d phases",
             n_loads, n_requests, n_granted, n_phases);
    $display("both fit modes, block counts from zero to above the table size, %0d mismatches",
             errors);
    if (errors == 0)
      $display("tb_fit_block_allocator: PASS");
    else
      $display("tb_fit_block_allocator: FAIL");
    $finish;
  end

endmodule
